@@ rtl/core/wpw_pkg.sv @@
`default_nettype none

package wpw_pkg;

  localparam int unsigned PHASE_BITS = 24;
  localparam int unsigned AMT_FRAC   = 16;
  localparam int unsigned AMT_BITS   = AMT_FRAC + 1;
  localparam int unsigned LOG_FRAC   = 16;
  localparam int unsigned QB         = 30;
  localparam int unsigned DIV_STEPS  = 24;
  localparam int unsigned LOG_WIDTH  = 21;
  localparam int unsigned E_WIDTH    = 19;
  localparam int unsigned DVD_WIDTH  = 48;
  localparam int unsigned DVS_WIDTH  = 25;

  localparam longint unsigned ONE_P_L    = 64'd1 << PHASE_BITS;
  localparam longint unsigned CLAMP_HI_L = (ONE_P_L * 64'd999999) / 64'd1000000;
  localparam longint unsigned EPS_L      = (ONE_P_L + 64'd999999) / 64'd1000000;

  localparam logic [16:0] ONE_A    = 17'd65536;
  localparam logic [23:0] HALF     = 24'd8388608;
  localparam logic [24:0] ONE_P    = 25'(ONE_P_L);
  localparam logic [23:0] CLAMP_HI = 24'(CLAMP_HI_L);
  localparam logic [24:0] EPS_P    = 25'(EPS_L);
  localparam logic [24:0] ST_TOP   = 25'(256 * 65536);
  localparam logic [24:0] ST_MIN   = 25'(4 * 65536);
  // ceil(2^29 / 10), exact floor division for values below 2^26
  localparam logic [25:0] RECIP10  = 26'd53687092;
  localparam int unsigned RECIP_SH = 29;

  typedef enum logic [2:0] {
    MODE_NONE,
    MODE_SYNC,
    MODE_BEND_UP,
    MODE_BEND_DN,
    MODE_MIRROR,
    MODE_ASYM,
    MODE_QUANT,
    MODE_FLIP
  } mode_e;

  typedef struct packed {
    mode_e                  mode;
    logic                   p_zero;
    logic                   use_div;
    logic [23:0]            r_simple;
    logic [DVD_WIDTH-1:0]   dvd;
    logic [DVS_WIDTH-1:0]   dvs;
    logic [E_WIDTH-1:0]     e;
    logic [23:0]            m_up;
  } wpw_side_t;

  typedef logic [LOG_FRAC-1:0][QB-1:0] coef_tbl_t;

  function automatic logic [63:0] isqrt64(input logic [63:0] v);
    logic [63:0] res;
    logic [63:0] bitv;
    logic [63:0] rem;
    res  = '0;
    rem  = v;
    bitv = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (rem >= res + bitv) begin
        rem = rem - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // c_i = 2^(-2^-(i+1)) in q30, built by repeated square roots
  function automatic coef_tbl_t gen_exp_coef();
    logic [63:0] c;
    coef_tbl_t   tbl;
    c = 64'd1 << (QB - 1);
    for (int i = 0; i < LOG_FRAC; i++) begin
      c = isqrt64(c << QB);
      tbl[i] = c[QB-1:0];
    end
    return tbl;
  endfunction

  localparam coef_tbl_t EXP_COEF = gen_exp_coef();

endpackage

`default_nettype wire

@@ rtl/core/wavetable_phase_warp_core.sv @@
// channel   direction  ports                                   handshake
// input     in         start, phase_in_i, warp_amount_i        start & !busy
// result    out        phase_out_valid_o, phase_out_o          strobe, one cycle
// config    in/out     psel, penable, pwrite, paddr, pwdata,   apb, pready tied high
//                      prdata, pready
// one beat in per cycle, busy is never raised
// a result passes through the front, the 16 squaring stages
// of the log, the 24 quotient-bit stages of the divider and 16 exp stages
// reset clears the valid bits and the mode register, no clearing pass
// the pipeline never stalls, so every result is shown for exactly one cycle
`default_nettype none

module wavetable_phase_warp_core import wpw_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [23:0] phase_in_i,
  input  wire logic [16:0] warp_amount_i,
  output logic             phase_out_valid_o,
  output logic [23:0]      phase_out_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  mode_e mode_q;

  assign pready = 1'b1;
  assign busy   = 1'b0;
  assign prdata = (paddr[2] == 1'b0) ? {29'b0, mode_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_NONE;
    end else if (psel && penable && pwrite && pready && (paddr[2] == 1'b0)) begin
      mode_q <= mode_e'(pwdata[2:0]);
    end
  end

  logic        fr_valid;
  wpw_side_t   fr_side;
  logic [30:0] fr_y;
  logic [4:0]  fr_k;
  logic        lg_valid;
  wpw_side_t   lg_side;
  logic        dv_valid;
  wpw_side_t   dv_side;
  logic [23:0] dv_quot;

  wpw_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (start && !busy),
    .phase_i  (phase_in_i),
    .amount_i (warp_amount_i),
    .mode_i   (mode_q),
    .valid_o  (fr_valid),
    .side_o   (fr_side),
    .y_o      (fr_y),
    .k_o      (fr_k)
  );

  wpw_log u_log (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (fr_valid),
    .side_i  (fr_side),
    .y_i     (fr_y),
    .k_i     (fr_k),
    .valid_o (lg_valid),
    .side_o  (lg_side)
  );

  wpw_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (lg_valid),
    .side_i  (lg_side),
    .valid_o (dv_valid),
    .side_o  (dv_side),
    .quot_o  (dv_quot)
  );

  wpw_exp u_exp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (dv_valid),
    .side_i  (dv_side),
    .quot_i  (dv_quot),
    .valid_o (phase_out_valid_o),
    .phase_o (phase_out_o)
  );

endmodule

`default_nettype wire

@@ rtl/core/wpw_front.sv @@
`default_nettype none

module wpw_front import wpw_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        valid_i,
  input  wire logic [23:0] phase_i,
  input  wire logic [16:0] amount_i,
  input  wire mode_e       mode_i,
  output logic             valid_o,
  output wpw_side_t        side_o,
  output logic [30:0]      y_o,
  output logic [4:0]       k_o
);

  // stage 0: saturate depth
  logic        v0_q;
  logic [23:0] p0_q;
  logic [16:0] a0_q;
  mode_e       mode0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else begin
      v0_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    p0_q    <= phase_i;
    a0_q    <= (amount_i > ONE_A) ? ONE_A : amount_i;
    mode0_q <= mode_i;
  end

  // stage 1: 0.3a, exponent, step count, msb position
  logic        v1_q;
  logic [23:0] p1_q;
  logic [16:0] a1_q;
  mode_e       mode1_q;
  logic [22:0] t1_q;
  logic [4:0]  k1_q;
  logic [18:0] e1_q;
  logic [24:0] st1_q;

  logic [25:0] x768;
  logic [51:0] t_prod;
  logic [4:0]  k_d;
  logic [24:0] st_raw;

  assign x768   = {a0_q, 9'b0} + {1'b0, a0_q, 8'b0};
  assign t_prod = 52'(x768) * 52'(RECIP10);
  assign st_raw = ST_TOP - 25'(a0_q) * 25'd252;

  always_comb begin
    k_d = '0;
    for (int i = 0; i < 24; i++) begin
      if (p0_q[i]) begin
        k_d = 5'(i);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= v0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    p1_q    <= p0_q;
    a1_q    <= a0_q;
    mode1_q <= mode0_q;
    t1_q    <= t_prod[RECIP_SH+22:RECIP_SH];
    k1_q    <= k_d;
    e1_q    <= 19'(ONE_A) + (19'(a0_q) << 1) + 19'(a0_q);
    st1_q   <= (st_raw < ST_MIN) ? ST_MIN : st_raw;
  end

  // stage 2: mid and slope points, sync, step index, log seed
  logic        v2_q;
  logic [23:0] p2_q;
  logic [16:0] a2_q;
  mode_e       mode2_q;
  logic [23:0] mid2_q;
  logic [23:0] s2_q;
  logic [24:0] st2_q;
  logic [18:0] e2_q;
  logic [30:0] y2_q;
  logic [4:0]  k2_q;
  logic [23:0] sync2_q;
  logic [7:0]  qn2_q;

  logic [19:0] sync_mul;
  logic [43:0] sync_prod;
  logic [48:0] qn_prod;
  logic [23:0] x_seed;

  assign sync_mul  = 20'(ONE_A) + 20'(a1_q) * 20'd7;
  assign sync_prod = 44'(p1_q) * 44'(sync_mul);
  assign qn_prod   = 49'(p1_q) * 49'(st1_q);
  assign x_seed    = (p1_q == '0) ? 24'd1 : p1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    p2_q    <= p1_q;
    a2_q    <= a1_q;
    mode2_q <= mode1_q;
    mid2_q  <= HALF - 24'(t1_q);
    s2_q    <= HALF + 24'(t1_q);
    st2_q   <= st1_q;
    e2_q    <= e1_q;
    y2_q    <= 31'(x_seed) << (5'd30 - k1_q);
    k2_q    <= k1_q;
    sync2_q <= sync_prod[39:16];
    qn2_q   <= qn_prod[47:40];
  end

  // stage 3: direct modes and divider operands
  logic [23:0] dlo;
  logic [48:0] asym_lo_prod;
  logic [23:0] ws;
  logic [47:0] asym_hi_prod;
  logic [40:0] flip_prod;
  logic [24:0] two_mid;
  logic        p_above;
  wpw_side_t   side_d;

  assign dlo          = {p2_q[22:0], 1'b0};
  assign asym_lo_prod = 49'({p2_q, 1'b0}) * 49'(s2_q);
  assign ws           = 24'(ONE_P - 25'(s2_q));
  assign asym_hi_prod = 48'(dlo) * 48'(ws);
  assign flip_prod    = 41'(dlo) * 41'(a2_q);
  assign two_mid      = {mid2_q, 1'b0};
  assign p_above      = p2_q > mid2_q;

  always_comb begin
    side_d          = '0;
    side_d.mode     = mode2_q;
    side_d.p_zero   = (p2_q == '0);
    side_d.e        = e2_q;
    side_d.dvs      = 25'd1;
    side_d.r_simple = p2_q;
    case (mode2_q)
      MODE_SYNC: side_d.r_simple = sync2_q;
      MODE_ASYM: begin
        if (!p2_q[23]) begin
          side_d.r_simple = asym_lo_prod[47:24];
        end else begin
          side_d.r_simple = s2_q + asym_hi_prod[47:24];
        end
      end
      MODE_FLIP: begin
        if (p2_q[23]) begin
          side_d.r_simple = p2_q - flip_prod[39:16];
        end
      end
      MODE_MIRROR: begin
        if (p_above) begin
          side_d.r_simple = (two_mid >= 25'(p2_q)) ? 24'(two_mid - 25'(p2_q)) : '0;
        end else begin
          side_d.use_div = 1'b1;
          side_d.dvd     = 48'(p2_q) << 23;
          side_d.dvs     = (25'(mid2_q) > EPS_P) ? 25'(mid2_q) : EPS_P;
        end
      end
      MODE_QUANT: begin
        side_d.use_div = 1'b1;
        side_d.dvd     = {qn2_q, 40'b0};
        side_d.dvs     = st2_q;
      end
      default: ;
    endcase
  end

  logic v3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    side_o <= side_d;
    y_o    <= y2_q;
    k_o    <= k2_q;
  end

  assign valid_o = v3_q;

endmodule

`default_nettype wire

@@ rtl/core/wpw_log.sv @@
`default_nettype none

module wpw_log import wpw_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        valid_i,
  input  wire wpw_side_t   side_i,
  input  wire logic [30:0] y_i,
  input  wire logic [4:0]  k_i,
  output logic             valid_o,
  output wpw_side_t        side_o
);

  logic              v_q    [LOG_FRAC];
  wpw_side_t         side_q [LOG_FRAC];
  logic [30:0]       y_q    [LOG_FRAC];
  logic [LOG_FRAC-1:0] fr_q [LOG_FRAC];
  logic [4:0]        k_q    [LOG_FRAC];

  for (genvar g = 0; g < LOG_FRAC; g++) begin : g_sq
    logic                v_in;
    wpw_side_t           side_in;
    logic [30:0]         y_in;
    logic [LOG_FRAC-1:0] fr_in;
    logic [4:0]          k_in;
    logic [61:0]         sq;

    if (g == 0) begin : g_first
      assign v_in    = valid_i;
      assign side_in = side_i;
      assign y_in    = y_i;
      assign fr_in   = '0;
      assign k_in    = k_i;
    end else begin : g_next
      assign v_in    = v_q[g-1];
      assign side_in = side_q[g-1];
      assign y_in    = y_q[g-1];
      assign fr_in   = fr_q[g-1];
      assign k_in    = k_q[g-1];
    end

    assign sq = 62'(y_in) * 62'(y_in);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[g] <= 1'b0;
      end else begin
        v_q[g] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      side_q[g] <= side_in;
      k_q[g]    <= k_in;
      if (sq[61]) begin
        y_q[g]  <= sq[61:31];
        fr_q[g] <= {fr_in[LOG_FRAC-2:0], 1'b1};
      end else begin
        y_q[g]  <= sq[60:30];
        fr_q[g] <= {fr_in[LOG_FRAC-2:0], 1'b0};
      end
    end
  end

  // -log2 of the phase, then bend-up product and bend-down operands
  logic [LOG_WIDTH-1:0] l_d;
  logic [39:0]          up_prod;
  wpw_side_t            side_d;
  logic                 vo_q;

  assign l_d     = {5'(PHASE_BITS) - k_q[LOG_FRAC-1], 16'b0}
                   - LOG_WIDTH'(fr_q[LOG_FRAC-1]);
  assign up_prod = 40'(l_d) * 40'(side_q[LOG_FRAC-1].e);

  always_comb begin
    side_d      = side_q[LOG_FRAC-1];
    side_d.m_up = up_prod[39:16];
    if (side_d.mode == MODE_BEND_DN) begin
      side_d.dvd = 48'(l_d) << AMT_FRAC;
      side_d.dvs = 25'(side_d.e);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vo_q <= 1'b0;
    end else begin
      vo_q <= v_q[LOG_FRAC-1];
    end
  end

  always_ff @(posedge clk_i) begin
    side_o <= side_d;
  end

  assign valid_o = vo_q;

endmodule

`default_nettype wire

@@ rtl/core/wpw_div.sv @@
`default_nettype none

module wpw_div import wpw_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      valid_i,
  input  wire wpw_side_t side_i,
  output logic           valid_o,
  output wpw_side_t      side_o,
  output logic [23:0]    quot_o
);

  logic           v_q    [DIV_STEPS];
  wpw_side_t      side_q [DIV_STEPS];
  logic [24:0]    rem_q  [DIV_STEPS];
  logic [23:0]    q_q    [DIV_STEPS];

  for (genvar g = 0; g < DIV_STEPS; g++) begin : g_step
    logic        v_in;
    wpw_side_t   side_in;
    logic [24:0] rem_in;
    logic [23:0] q_in;
    logic [25:0] trial;
    logic        fits;

    if (g == 0) begin : g_first
      assign v_in    = valid_i;
      assign side_in = side_i;
      assign rem_in  = {1'b0, side_i.dvd[DVD_WIDTH-1:DIV_STEPS]};
      assign q_in    = '0;
    end else begin : g_next
      assign v_in    = v_q[g-1];
      assign side_in = side_q[g-1];
      assign rem_in  = rem_q[g-1];
      assign q_in    = q_q[g-1];
    end

    assign trial = {rem_in, side_in.dvd[DIV_STEPS-1-g]};
    assign fits  = trial >= {1'b0, side_in.dvs};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[g] <= 1'b0;
      end else begin
        v_q[g] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      side_q[g] <= side_in;
      q_q[g]    <= {q_in[22:0], fits};
      rem_q[g]  <= fits ? 25'(trial - {1'b0, side_in.dvs}) : trial[24:0];
    end
  end

  assign valid_o = v_q[DIV_STEPS-1];
  assign side_o  = side_q[DIV_STEPS-1];
  assign quot_o  = q_q[DIV_STEPS-1];

endmodule

`default_nettype wire

@@ rtl/core/wpw_exp.sv @@
`default_nettype none

module wpw_exp import wpw_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        valid_i,
  input  wire wpw_side_t   side_i,
  input  wire logic [23:0] quot_i,
  output logic             valid_o,
  output logic [23:0]      phase_o
);

  logic        v_q    [LOG_FRAC];
  wpw_side_t   side_q [LOG_FRAC];
  logic [23:0] quot_q [LOG_FRAC];
  logic [23:0] m_q    [LOG_FRAC];
  logic [30:0] r_q    [LOG_FRAC];

  logic [23:0] m_sel;

  assign m_sel = (side_i.mode == MODE_BEND_DN) ? quot_i : side_i.m_up;

  for (genvar g = 0; g < LOG_FRAC; g++) begin : g_mul
    logic        v_in;
    wpw_side_t   side_in;
    logic [23:0] quot_in;
    logic [23:0] m_in;
    logic [30:0] r_in;
    logic [60:0] prod;

    if (g == 0) begin : g_first
      assign v_in    = valid_i;
      assign side_in = side_i;
      assign quot_in = quot_i;
      assign m_in    = m_sel;
      assign r_in    = 31'd1 << QB;
    end else begin : g_next
      assign v_in    = v_q[g-1];
      assign side_in = side_q[g-1];
      assign quot_in = quot_q[g-1];
      assign m_in    = m_q[g-1];
      assign r_in    = r_q[g-1];
    end

    assign prod = 61'(r_in) * 61'(EXP_COEF[g]);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[g] <= 1'b0;
      end else begin
        v_q[g] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      side_q[g] <= side_in;
      quot_q[g] <= quot_in;
      m_q[g]    <= m_in;
      r_q[g]    <= m_in[LOG_FRAC-1-g] ? prod[60:30] : r_in;
    end
  end

  // integer part of the exponent, mode select and clamp
  wpw_side_t   side_l;
  logic [7:0]  n_int;
  logic [4:0]  sh_amt;
  logic [30:0] r_sh;
  logic [24:0] ex_val;
  logic [24:0] res_d;
  logic        vo_q;

  assign side_l = side_q[LOG_FRAC-1];
  assign n_int  = m_q[LOG_FRAC-1][23:16];
  assign sh_amt = n_int[4:0] + 5'd6;
  assign r_sh   = r_q[LOG_FRAC-1] >> sh_amt;
  assign ex_val = (n_int >= 8'd25) ? '0 : r_sh[24:0];

  always_comb begin
    case (side_l.mode)
      MODE_BEND_UP, MODE_BEND_DN: res_d = side_l.p_zero ? '0 : ex_val;
      MODE_MIRROR, MODE_QUANT: begin
        res_d = side_l.use_div ? 25'(quot_q[LOG_FRAC-1]) : 25'(side_l.r_simple);
      end
      default: res_d = 25'(side_l.r_simple);
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vo_q <= 1'b0;
    end else begin
      vo_q <= v_q[LOG_FRAC-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (side_l.mode != MODE_NONE && res_d > 25'(CLAMP_HI)) begin
      phase_o <= CLAMP_HI;
    end else begin
      phase_o <= res_d[23:0];
    end
  end

  assign valid_o = vo_q;

endmodule

`default_nettype wire
